// ===== rtl/throttle_to_servo_fuel_map_defines.svh =====
// ----------------------------------------------------------------------------
// Throttle-to-servo fuel map: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef THROTTLE_TO_SERVO_FUEL_MAP_DEFINES_SVH
`define THROTTLE_TO_SERVO_FUEL_MAP_DEFINES_SVH

// same-cycle implication
`define TSFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tsfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Throttle-to-servo fuel map: package
// Shared widths, register map, configuration struct and sequencer states.
// ----------------------------------------------------------------------------
package tsfm_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned RPM_W    = 15;
  localparam int unsigned SMOOTH_W = 12;
  localparam int unsigned PCT_W    = 14;
  localparam int unsigned DEG_W    = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // divisor width (span * 256 is the widest) and compensation numerator width
  localparam int unsigned DEN_W = 20;
  localparam int unsigned NUM_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_SPAN_LOW   = 3'd0,
    CFG_ADC_SPAN_HIGH  = 3'd1,
    CFG_DEAD_ZONE_LOW  = 3'd2,
    CFG_DEAD_ZONE_HIGH = 3'd3,
    CFG_ANGLE_CLOSED   = 3'd4,
    CFG_ANGLE_FULL     = 3'd5,
    CFG_COMP_FACTOR    = 3'd6,
    CFG_COMP_REF_RPM   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] adc_span_low;
    logic [11:0] adc_span_high;
    logic [13:0] dead_zone_low;
    logic [13:0] dead_zone_high;
    logic [10:0] angle_closed;
    logic [10:0] angle_full;
    logic [9:0]  comp_factor;
    logic [14:0] comp_ref_rpm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    adc_span_low:   12'd0,
    adc_span_high:  12'd4095,
    dead_zone_low:  14'd0,
    dead_zone_high: 14'd10000,
    angle_closed:   11'd0,
    angle_full:     11'd1800,
    comp_factor:    10'd256,
    comp_ref_rpm:   15'd0
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_FLT_MUL,
    S_FLT_SET,
    S_PCT_MUL,
    S_PCT_DIV,
    S_PCT_WAIT,
    S_DZ_MUL,
    S_DZ_DIV,
    S_DZ_WAIT,
    S_ANG_MUL,
    S_ANG_RCP,
    S_ANG_SET,
    S_CMP_MUL,
    S_CMP_NUM,
    S_CMP_SCALE,
    S_CMP_DIV,
    S_CMP_WAIT,
    S_DEG_MUL,
    S_OUT
  } state_t;

endpackage

// ===== rtl/tsfm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Throttle-to-servo fuel map: configuration registers
// Write-only register file; values are truncated to their field widths.
// ----------------------------------------------------------------------------
module tsfm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tsfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tsfm_pkg::cfg_t                   cfg
);

  tsfm_pkg::cfg_t cfg_r;
  tsfm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (tsfm_pkg::cfg_idx_t'(cfg_index))
        tsfm_pkg::CFG_ADC_SPAN_LOW:   cfg_nxt.adc_span_low   = cfg_wdata[11:0];
        tsfm_pkg::CFG_ADC_SPAN_HIGH:  cfg_nxt.adc_span_high  = cfg_wdata[11:0];
        tsfm_pkg::CFG_DEAD_ZONE_LOW:  cfg_nxt.dead_zone_low  = cfg_wdata[13:0];
        tsfm_pkg::CFG_DEAD_ZONE_HIGH: cfg_nxt.dead_zone_high = cfg_wdata[13:0];
        tsfm_pkg::CFG_ANGLE_CLOSED:   cfg_nxt.angle_closed   = cfg_wdata[10:0];
        tsfm_pkg::CFG_ANGLE_FULL:     cfg_nxt.angle_full     = cfg_wdata[10:0];
        tsfm_pkg::CFG_COMP_FACTOR:    cfg_nxt.comp_factor    = cfg_wdata[9:0];
        tsfm_pkg::CFG_COMP_REF_RPM:   cfg_nxt.comp_ref_rpm   = cfg_wdata[14:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tsfm_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/tsfm_div.sv =====
// ----------------------------------------------------------------------------
// Throttle-to-servo fuel map: shared divider
// Restoring unsigned divider, one quotient bit per cycle, k bits per run.
// ----------------------------------------------------------------------------
module tsfm_div #(
  parameter  int unsigned NW = 45,
  parameter  int unsigned DW = 20,
  parameter  int unsigned KW = 20,
  localparam int unsigned CW = $clog2(KW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [CW-1:0] k,
  output logic          done,
  output logic [KW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [KW-1:0] sh_r, sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [NW-1:0] num_hi;
  logic [NW-1:0] num_lo;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // high part seeds the remainder, low k bits go left-aligned into the shifter
  assign num_hi = num >> k;
  assign num_lo = num << (CW'(KW) - k);
  assign trial  = {rem_r, sh_r[KW-1]};
  assign diff   = trial - {1'b0, den_r};
  assign ge     = ~diff[DW];

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    if (start) begin
      den_nxt  = den;
      rem_nxt  = num_hi[DW-1:0];
      sh_nxt   = num_lo[KW-1:0];
      cnt_nxt  = k;
      busy_nxt = 1'b1;
      ovf_nxt  = (num_hi >= NW'(den));
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_nxt  = {sh_r[KW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
    ovf_r <= ovf_nxt;
  end

  // quotient holds until the next start
  assign done = done_r;
  assign quo  = sh_r;
  assign ovf  = ovf_r;

endmodule

// ===== rtl/throttle_to_servo_fuel_map.sv =====
// ----------------------------------------------------------------------------
// Throttle-to-servo fuel map
// Smoothed throttle ADC sample to dead-zoned percent and servo angle.
// ----------------------------------------------------------------------------
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+-----------------
//  in      | in_adc_sample, in_engine_rpm               | in_valid/in_stall
//  out     | out_smoothed_adc, out_throttle_pct,        | out_valid/out_stall
//          | out_servo_angle                            |
//  cfg     | cfg_index, cfg_wdata                       | cfg_we, no wait
//
//  Up to three 14-bit divisions run on the shared divider at one quotient bit
//  a cycle, the third only with RPM compensation on; a span or dead-zone
//  division is skipped when its result is known to be 0. /5, /10000 and /10
//  are reciprocal multiplies on the shared multiplier.
//  One transaction in flight; in_stall is high from accept until the result
//  moves into the output register. Reset clears the filter and loads defaults.
//
`include "throttle_to_servo_fuel_map_defines.svh"

module throttle_to_servo_fuel_map #(
  parameter int unsigned ADC_BITS = tsfm_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [tsfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADC_BITS-1:0]              in_adc_sample,
  input  logic [tsfm_pkg::RPM_W-1:0]       in_engine_rpm,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tsfm_pkg::SMOOTH_W-1:0]    out_smoothed_adc,
  output logic [tsfm_pkg::PCT_W-1:0]       out_throttle_pct,
  output logic [tsfm_pkg::DEG_W-1:0]       out_servo_angle
);

  // filter is 12.8 style: ADC_BITS integer bits, 8 fraction bits
  localparam int unsigned FW  = ADC_BITS + 8;
  localparam int unsigned FNW = FW + 3;            // 4*filter + sample<<8
  // |filter - span_low*256| magnitude width
  localparam int unsigned DM  = (FW > tsfm_pkg::DEN_W) ? FW : tsfm_pkg::DEN_W;
  localparam int unsigned DS  = DM + 1;
  localparam int unsigned AP_W = 25;               // pct * |angle span| < 2^25
  localparam int unsigned MA1 = (DM > FNW) ? DM : FNW;
  localparam int unsigned MA  = (MA1 > AP_W) ? MA1 : AP_W;
  localparam int unsigned MB  = (FNW > tsfm_pkg::NUM_W) ? FNW : tsfm_pkg::NUM_W;
  localparam int unsigned PW  = MA + MB;
  localparam int unsigned DEN_W = tsfm_pkg::DEN_W;
  localparam int unsigned PCT_W = tsfm_pkg::PCT_W;

  // quotient bits per division; each result is known to stay below 2^k,
  // or is clamped when the divider flags overflow
  localparam int unsigned K_PCT = 14;
  localparam int unsigned K_DZ  = 14;
  localparam int unsigned K_CMP = 14;
  localparam int unsigned KW  = K_PCT;
  localparam int unsigned CW  = $clog2(KW + 1);

  // reciprocals: ceil(2^s/d); exact since numerator * error < 2^s
  localparam int unsigned FLT_SH = FNW + 2;
  localparam int unsigned ANG_SH = 38;
  localparam int unsigned DEG_SH = 14;
  localparam logic [MB-1:0] RCP_FLT = MB'(((64'd1 << FLT_SH) + 64'd4) / 64'd5);
  localparam logic [MB-1:0] RCP_ANG = MB'(((64'd1 << ANG_SH) + 64'd9999) / 64'd10000);
  localparam logic [MB-1:0] RCP_DEG = MB'(((64'd1 << DEG_SH) + 64'd9) / 64'd10);

  localparam logic [PCT_W-1:0] PCT_FULL  = 14'd10000;
  localparam logic [10:0]      ANGLE_MAX = 11'd1800;

  tsfm_pkg::cfg_t cfg;

  tsfm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  tsfm_pkg::state_t             state_r, state_nxt;
  logic [ADC_BITS-1:0]          raw_r, raw_nxt;
  logic [tsfm_pkg::RPM_W-1:0]   rpm_r, rpm_nxt;
  logic [FW-1:0]                fv_r, fv_nxt;
  logic                         primed_r, primed_nxt;
  logic [PW-1:0]                prod_r;
  logic [PCT_W-1:0]             rp_r, rp_nxt;      // raw percent before dead zone
  logic [PCT_W-1:0]             pct_r, pct_nxt;
  logic [12:0]                  ang_r, ang_nxt;    // tenths of a degree
  logic [MB-1:0]                comp_num_r, comp_num_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tsfm_pkg::SMOOTH_W-1:0] sm_r;
  logic [PCT_W-1:0]             opct_r;
  logic [tsfm_pkg::DEG_W-1:0]   deg_r;
  logic                         out_load;

  // shared multiplier
  logic [MA-1:0]                mul_a;
  logic [MB-1:0]                mul_b;
  logic [PW-1:0]                mul_p;
  logic                         prod_en;

  // shared divider
  logic                         div_start;
  logic [PW-1:0]                div_num;
  logic [DEN_W-1:0]             div_den;
  logic [CW-1:0]                div_k;
  logic                         div_done;
  logic [KW-1:0]                div_quo;
  logic                         div_ovf;
  logic                         div_wait;

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic [FW-1:0]                fv_src;
  logic [FNW-1:0]               flt_num;
  logic signed [DS-1:0]         diff2;
  logic [DM-1:0]                diff2_mag;
  logic signed [12:0]           span;
  logic [11:0]                  span_mag;
  logic                         pct_skip;
  logic [14:0]                  dz_hi;
  logic [14:0]                  dz_den;
  logic                         dz_skip;
  logic [PCT_W-1:0]             dz_mag;
  logic signed [11:0]           ang_d;
  logic [10:0]                  ang_mag;
  logic [14:0]                  rpm_c;
  logic signed [10:0]           cfd;
  logic [9:0]                   cfd_mag;
  logic                         comp_on;
  logic [MB-1:0]                comp_base;
  logic [10:0]                  deg_in;
  logic [PCT_W-1:0]             quo_pct;
  logic [10:0]                  quo_ang;

  // first sample primes the filter with the sample itself
  assign fv_src  = primed_r ? fv_r : {raw_r, 8'd0};
  assign flt_num = FNW'({fv_src, 2'b00}) + FNW'({raw_r, 8'd0});

  assign diff2     = $signed({1'b0, DM'(fv_r)})
                   - $signed({1'b0, DM'({cfg.adc_span_low, 8'd0})});
  assign diff2_mag = diff2[DM] ? DM'(-diff2) : diff2[DM-1:0];
  assign span      = $signed({1'b0, cfg.adc_span_high}) - $signed({1'b0, cfg.adc_span_low});
  assign span_mag  = span[12] ? 12'(-span) : span[11:0];
  // zero span, zero distance or opposite signs all land on 0 after clamping
  assign pct_skip  = (span == 13'sd0) || (diff2 == '0) || (diff2[DM] != span[12]);

  // empty window widens to one percent
  assign dz_hi   = (cfg.dead_zone_high <= cfg.dead_zone_low) ?
                   ({1'b0, cfg.dead_zone_low} + 15'd100) : {1'b0, cfg.dead_zone_high};
  assign dz_den  = dz_hi - {1'b0, cfg.dead_zone_low};
  assign dz_skip = (rp_r <= cfg.dead_zone_low);
  assign dz_mag  = rp_r - cfg.dead_zone_low;

  assign ang_d   = $signed({1'b0, cfg.angle_full}) - $signed({1'b0, cfg.angle_closed});
  assign ang_mag = ang_d[11] ? 11'(-ang_d) : ang_d[10:0];

  assign rpm_c     = (rpm_r > cfg.comp_ref_rpm) ? cfg.comp_ref_rpm : rpm_r;
  assign cfd       = $signed({1'b0, cfg.comp_factor}) - 11'sd256;
  assign cfd_mag   = cfd[10] ? 10'(-cfd) : cfd[9:0];
  assign comp_on   = (cfg.comp_factor != 10'd256) && (cfg.comp_ref_rpm != 15'd0);
  assign comp_base = MB'({cfg.comp_ref_rpm, 8'd0});

  assign deg_in  = (ang_r > 13'(ANGLE_MAX)) ? ANGLE_MAX : ang_r[10:0];
  assign quo_pct = div_quo[PCT_W-1:0];
  // pct * |angle span| / 10000 via the reciprocal product
  assign quo_ang = prod_r[ANG_SH +: 11];

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  tsfm_div #(
    .NW (PW),
    .DW (DEN_W),
    .KW (KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .k     (div_k),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    raw_nxt      = raw_r;
    rpm_nxt      = rpm_r;
    fv_nxt       = fv_r;
    primed_nxt   = primed_r;
    rp_nxt       = rp_r;
    pct_nxt      = pct_r;
    ang_nxt      = ang_r;
    comp_num_nxt = comp_num_r;
    prod_en      = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    div_k        = '0;
    out_load     = 1'b0;

    case (state_r)
      tsfm_pkg::S_IDLE: begin
        if (in_valid) begin
          raw_nxt   = in_adc_sample;
          rpm_nxt   = in_engine_rpm;
          state_nxt = tsfm_pkg::S_FLT_MUL;
        end
      end

      // filter: (4*old + new) / 5 by reciprocal multiply
      tsfm_pkg::S_FLT_MUL: begin
        prod_en   = 1'b1;
        mul_a     = MA'(flt_num);
        mul_b     = RCP_FLT;
        state_nxt = tsfm_pkg::S_FLT_SET;
      end
      tsfm_pkg::S_FLT_SET: begin
        fv_nxt     = prod_r[FLT_SH +: FW];
        primed_nxt = 1'b1;
        state_nxt  = tsfm_pkg::S_PCT_MUL;
      end

      // calibration span to percent
      tsfm_pkg::S_PCT_MUL: begin
        prod_en = 1'b1;
        mul_a   = MA'(diff2_mag);
        mul_b   = MB'(PCT_FULL);
        if (pct_skip) begin
          rp_nxt    = '0;
          state_nxt = tsfm_pkg::S_DZ_MUL;
        end else begin
          state_nxt = tsfm_pkg::S_PCT_DIV;
        end
      end
      tsfm_pkg::S_PCT_DIV: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = DEN_W'({span_mag, 8'd0});
        div_k     = CW'(K_PCT);
        state_nxt = tsfm_pkg::S_PCT_WAIT;
      end
      tsfm_pkg::S_PCT_WAIT: begin
        if (div_done) begin
          rp_nxt    = (div_ovf || (quo_pct > PCT_FULL)) ? PCT_FULL : quo_pct;
          state_nxt = tsfm_pkg::S_DZ_MUL;
        end
      end

      // dead zone
      tsfm_pkg::S_DZ_MUL: begin
        prod_en = 1'b1;
        mul_a   = MA'(dz_mag);
        mul_b   = MB'(PCT_FULL);
        if (dz_skip) begin
          pct_nxt   = '0;
          state_nxt = tsfm_pkg::S_ANG_MUL;
        end else begin
          state_nxt = tsfm_pkg::S_DZ_DIV;
        end
      end
      tsfm_pkg::S_DZ_DIV: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = DEN_W'(dz_den);
        div_k     = CW'(K_DZ);
        state_nxt = tsfm_pkg::S_DZ_WAIT;
      end
      tsfm_pkg::S_DZ_WAIT: begin
        if (div_done) begin
          pct_nxt   = (div_ovf || (quo_pct > PCT_FULL)) ? PCT_FULL : quo_pct;
          state_nxt = tsfm_pkg::S_ANG_MUL;
        end
      end

      // angle interpolation, sign-magnitude so the quotient truncates to zero
      tsfm_pkg::S_ANG_MUL: begin
        prod_en   = 1'b1;
        mul_a     = MA'(pct_r);
        mul_b     = MB'(ang_mag);
        state_nxt = tsfm_pkg::S_ANG_RCP;
      end
      tsfm_pkg::S_ANG_RCP: begin
        prod_en   = 1'b1;
        mul_a     = MA'(prod_r[AP_W-1:0]);
        mul_b     = RCP_ANG;
        state_nxt = tsfm_pkg::S_ANG_SET;
      end
      tsfm_pkg::S_ANG_SET: begin
        ang_nxt   = ang_d[11] ? (13'(cfg.angle_closed) - 13'(quo_ang)) :
                                (13'(cfg.angle_closed) + 13'(quo_ang));
        state_nxt = comp_on ? tsfm_pkg::S_CMP_MUL : tsfm_pkg::S_DEG_MUL;
      end

      // RPM compensation: angle * (256*ref + (cf-256)*rpm) / (256*ref)
      tsfm_pkg::S_CMP_MUL: begin
        prod_en   = 1'b1;
        mul_a     = MA'(rpm_c);
        mul_b     = MB'(cfd_mag);
        state_nxt = tsfm_pkg::S_CMP_NUM;
      end
      tsfm_pkg::S_CMP_NUM: begin
        comp_num_nxt = cfd[10] ? (comp_base - prod_r[MB-1:0]) :
                                 (comp_base + prod_r[MB-1:0]);
        state_nxt    = tsfm_pkg::S_CMP_SCALE;
      end
      tsfm_pkg::S_CMP_SCALE: begin
        prod_en   = 1'b1;
        mul_a     = MA'(ang_r);
        mul_b     = comp_num_r;
        state_nxt = tsfm_pkg::S_CMP_DIV;
      end
      tsfm_pkg::S_CMP_DIV: begin
        // floor(floor(x/256)/ref) == floor(x/(256*ref))
        div_start = 1'b1;
        div_num   = prod_r >> 8;
        div_den   = DEN_W'(cfg.comp_ref_rpm);
        div_k     = CW'(K_CMP);
        state_nxt = tsfm_pkg::S_CMP_WAIT;
      end
      tsfm_pkg::S_CMP_WAIT: begin
        if (div_done) begin
          ang_nxt   = div_quo[12:0];
          state_nxt = tsfm_pkg::S_DEG_MUL;
        end
      end

      // saturate and drop to whole degrees (/10 by reciprocal multiply)
      tsfm_pkg::S_DEG_MUL: begin
        prod_en   = 1'b1;
        mul_a     = MA'(deg_in);
        mul_b     = RCP_DEG;
        state_nxt = tsfm_pkg::S_OUT;
      end

      // degree product holds in prod_r while the output register is busy
      tsfm_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = tsfm_pkg::S_IDLE;
        end
      end

      default: state_nxt = tsfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsfm_pkg::S_IDLE;
      primed_r    <= 1'b0;
      fv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    rpm_r      <= rpm_nxt;
    rp_r       <= rp_nxt;
    pct_r      <= pct_nxt;
    ang_r      <= ang_nxt;
    comp_num_r <= comp_num_nxt;
    if (prod_en) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      sm_r   <= tsfm_pkg::SMOOTH_W'(fv_r >> 8);
      opct_r <= pct_r;
      deg_r  <= prod_r[DEG_SH +: tsfm_pkg::DEG_W];
    end
  end

  assign in_stall         = (state_r != tsfm_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_smoothed_adc = sm_r;
  assign out_throttle_pct = opct_r;
  assign out_servo_angle  = deg_r;

  assign div_wait = (state_r == tsfm_pkg::S_PCT_WAIT) || (state_r == tsfm_pkg::S_DZ_WAIT) ||
                    (state_r == tsfm_pkg::S_CMP_WAIT);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `TSFM_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not start work")
  `TSFM_ASSERT_IMP(a_div_done_in_wait, div_done, div_wait, "divider done outside a wait state")
  `TSFM_ASSERT_NXT(a_result_posted, out_load, out_valid && !in_stall, "result load not posted")

endmodule
